[src/bec_pkg.sv]
// shared types, constants and escape map functions for the byte escape codec
package bec_pkg;

    localparam int BEC_QUEUE_DEPTH = 4;

    localparam logic [7:0] BACKSLASH = 8'h5C;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;

    localparam logic MODE_ESCAPE   = 1'b0;
    localparam logic MODE_UNESCAPE = 1'b1;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       last;
        logic       trunc;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

    function automatic logic is_plain(input logic [7:0] c);
        logic hit;
        case (c)
            8'h0A, 8'h2C, 8'h7C, 8'h5C: hit = 1'b1;
            default:                    hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [7:0] plain_to_code(input logic [7:0] c);
        logic [7:0] code;
        case (c)
            8'h0A:   code = 8'h6E;
            8'h2C:   code = 8'h63;
            8'h7C:   code = 8'h7A;
            8'h5C:   code = 8'h79;
            default: code = c;
        endcase
        return code;
    endfunction

    // unmapped codes pass through unchanged
    function automatic logic [7:0] code_to_plain(input logic [7:0] c);
        logic [7:0] plain;
        case (c)
            8'h6E:   plain = 8'h0A;
            8'h63:   plain = 8'h2C;
            8'h7A:   plain = 8'h7C;
            8'h79:   plain = 8'h5C;
            default: plain = c;
        endcase
        return plain;
    endfunction

endpackage

[src/bec_core.sv]
// per-string state and result generation for one registered byte
module bec_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mode,
    input  logic [15:0]          out_limit,
    input  logic                 fire,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output bec_pkg::result_pair_t pair
);
    import bec_pkg::*;

    logic        pending_reg;
    logic        pending_next;
    logic [15:0] written_reg;
    logic [15:0] written_next;
    logic        stopped_reg;
    logic        stopped_next;

    logic [16:0] sum1;
    logic [16:0] sum2;
    logic [16:0] limit_ext;
    logic        hit;

    assign sum1      = {1'b0, written_reg} + 17'd1;
    assign sum2      = {1'b0, written_reg} + 17'd2;
    assign limit_ext = {1'b0, out_limit};
    assign hit       = is_plain(in_byte);

    always_comb
    begin
        pair         = '0;
        pending_next = pending_reg;
        written_next = written_reg;
        stopped_next = stopped_reg;

        if (mode == MODE_ESCAPE)
        begin
            if (!stopped_reg)
            begin
                if (sum1 >= limit_ext)
                begin
                    stopped_next = 1'b1;
                end
                else if (hit)
                begin
                    if (sum2 < limit_ext)
                    begin
                        pair.count  = 2'd2;
                        pair.first  = '{data: BACKSLASH, byte_valid: 1'b1,
                                        last: 1'b0, trunc: 1'b0};
                        pair.second = '{data: plain_to_code(in_byte), byte_valid: 1'b1,
                                        last: in_last, trunc: 1'b0};
                        written_next = sum2[15:0];
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
                else
                begin
                    pair.count   = 2'd1;
                    pair.first   = '{data: in_byte, byte_valid: 1'b1,
                                     last: in_last, trunc: 1'b0};
                    written_next = sum1[15:0];
                end
            end
            // end marker when nothing else carries the last flag
            if (pair.count == 2'd0 && in_last)
            begin
                pair.count = 2'd1;
                pair.first = '{data: 8'h00, byte_valid: 1'b0,
                               last: 1'b1, trunc: stopped_next};
            end
        end
        else
        begin
            if (pending_reg)
            begin
                pending_next = 1'b0;
                pair.count   = 2'd1;
                pair.first   = '{data: code_to_plain(in_byte), byte_valid: 1'b1,
                                 last: in_last, trunc: 1'b0};
            end
            else if (in_byte == BACKSLASH)
            begin
                if (in_last)
                begin
                    // lone backslash at the end gives a zero byte
                    pair.count = 2'd1;
                    pair.first = '{data: 8'h00, byte_valid: 1'b1,
                                   last: 1'b1, trunc: 1'b0};
                end
                else
                begin
                    pending_next = 1'b1;
                end
            end
            else
            begin
                pair.count = 2'd1;
                pair.first = '{data: in_byte, byte_valid: 1'b1,
                               last: in_last, trunc: 1'b0};
            end
        end

        if (in_last)
        begin
            pending_next = 1'b0;
            written_next = '0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            written_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else if (fire)
        begin
            pending_reg <= pending_next;
            written_reg <= written_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

[src/byte_escape_codec.sv]
// byte escape codec: input register, codec core and result queue
// a byte waits in the input register until it is processed into the result queue
// one result per cycle out while out_stall is low; one input per cycle while each
// gives a single byte; with one result port on the queue, an escaped pair slows input
// an input is taken while the input stage is empty or at least two queue slots are free
// reset clears configuration to escape mode with limit 65535 and empties all stages
module byte_escape_codec #(
    parameter int QUEUE_DEPTH = bec_pkg::BEC_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        out_last,
    output logic        truncated
);
    import bec_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic        mode_reg;
    logic [15:0] limit_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    result_t      q_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [PW-1:0] wr_ptr1;
    logic [PW-1:0] wr_ptr2;

    result_pair_t pair;
    logic         process;
    logic         load;
    logic         pop;
    logic [CW-1:0] push_n;
    result_t      head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ESCAPE;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[0];
                CFG_LIMIT: limit_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // the registered byte is processed once the queue can absorb a pair
    assign process  = s1_valid_reg && (count_reg <= CW'(QUEUE_DEPTH - 2));
    assign in_stall = s1_valid_reg && !process;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load || process)
        begin
            s1_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
    end

    bec_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .out_limit (limit_reg),
        .fire      (process),
        .in_byte   (s1_byte_reg),
        .in_last   (s1_last_reg),
        .pair      (pair)
    );

    assign wr_ptr1 = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
    assign wr_ptr2 = (wr_ptr1 == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr1 + PW'(1);

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign push_n    = process ? CW'(pair.count) : '0;
    assign head      = q_reg[rd_ptr_reg];

    assign out_byte   = head.data;
    assign byte_valid = head.byte_valid;
    assign out_last   = head.last;
    assign truncated  = head.trunc;

    always_comb
    begin
        count_next  = count_reg + push_n - CW'(pop);
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case (push_n)
            CW'(1):  wr_ptr_next = wr_ptr1;
            CW'(2):  wr_ptr_next = wr_ptr2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && pair.count != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= pair.first;
        end
        if (process && pair.count == 2'd2)
        begin
            q_reg[wr_ptr1] <= pair.second;
        end
    end

endmodule

[src/bec_checker.sv]
// port-level checks for the byte escape codec and their bind
module bec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic        byte_valid,
    input logic        out_last,
    input logic        truncated
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(byte_valid) && $stable(out_last) && $stable(truncated))
    else $error("result changed while stalled");

    // a truncated result is an end marker with no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> !byte_valid && out_last)
    else $error("truncated flag on a byte result");

    // an end marker is zero and always closes the string
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_last && out_byte == 8'h00)
    else $error("malformed end marker");

    // nothing is offered straight out of reset
    assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("result offered out of reset");

endmodule

bind byte_escape_codec bec_checker u_bec_checker (.*);

[bench/byte_escape_codec_chk.sv]
`timescale 1ns / 1ps
// transaction checker for the byte escape codec: predicts every result and compares it
module byte_escape_codec_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        byte_valid,
    input  logic        out_last,
    input  logic        truncated,
    output int          mismatch_count,
    output int          owed_count
);
    import bec_pkg::*;

    // slot i of one map pairs with slot i of the other
    localparam logic [3:0][7:0] RAW_CHARS = {8'h5C, 8'h7C, 8'h2C, 8'h0A};
    localparam logic [3:0][7:0] ESC_CODES = {8'h79, 8'h7A, 8'h63, 8'h6E};
    localparam int              NO_SLOT   = 4;

    logic        cur_mode;
    logic [15:0] cur_limit;
    logic        esc_held;
    int unsigned written_cnt;
    logic        cut_off;
    result_t     owed_results[$];
    result_t     want;

    function automatic int find_slot(input logic [7:0] c, input logic by_code);
        int hit;
        hit = NO_SLOT;
        for (int i = 3; i >= 0; i--)
        begin
            if ((by_code ? ESC_CODES[i[1:0]] : RAW_CHARS[i[1:0]]) == c)
                hit = i;
        end
        return hit;
    endfunction

    task automatic owe(input logic [7:0] d, input logic v, input logic l, input logic t);
        result_t r;
        r.data       = d;
        r.byte_valid = v;
        r.last       = l;
        r.trunc      = t;
        owed_results.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic translate_char(input logic [7:0] ch, input logic fin);
        int slot;
        int made;
        made = 0;
        if (cur_mode == MODE_ESCAPE)
        begin
            if (!cut_off)
            begin
                slot = find_slot(ch, 1'b0);
                if (written_cnt + 1 >= cur_limit)
                    cut_off = 1'b1;
                else if (slot != NO_SLOT)
                begin
                    if (written_cnt + 2 < cur_limit)
                    begin
                        owe(BACKSLASH, 1'b1, 1'b0, 1'b0);
                        owe(ESC_CODES[slot[1:0]], 1'b1, fin, 1'b0);
                        written_cnt = (written_cnt + 2) & 32'hFFFF;
                        made = 2;
                    end
                    else
                        cut_off = 1'b1;
                end
                else
                begin
                    owe(ch, 1'b1, fin, 1'b0);
                    written_cnt = (written_cnt + 1) & 32'hFFFF;
                    made = 1;
                end
            end
            // a cut or silent last byte still closes the string with an end marker
            if (made == 0 && fin)
                owe(8'h00, 1'b0, 1'b1, cut_off);
        end
        else
        begin
            if (esc_held)
            begin
                slot = find_slot(ch, 1'b1);
                esc_held = 1'b0;
                owe((slot != NO_SLOT) ? RAW_CHARS[slot[1:0]] : ch, 1'b1, fin, 1'b0);
            end
            else if (ch == BACKSLASH)
            begin
                if (fin)
                    owe(8'h00, 1'b1, 1'b1, 1'b0);
                else
                    esc_held = 1'b1;
            end
            else
                owe(ch, 1'b1, fin, 1'b0);
        end
        if (fin)
        begin
            esc_held    = 1'b0;
            written_cnt = 0;
            cut_off     = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode       = MODE_ESCAPE;
            cur_limit      = LIMIT_RESET;
            esc_held       = 1'b0;
            written_cnt    = 0;
            cut_off        = 1'b0;
            mismatch_count = 0;
            owed_results.delete();
        end
        else
        begin
            // results first: nothing accepted at this edge can already be on the output
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                    report_mismatch($sformatf("unexpected result, byte %02h", out_byte));
                else
                begin
                    want = owed_results.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  out_byte, want.data));
                    if (byte_valid !== want.byte_valid)
                        report_mismatch($sformatf("byte_valid %b, want %b",
                                                  byte_valid, want.byte_valid));
                    if (out_last !== want.last)
                        report_mismatch($sformatf("out_last %b, want %b",
                                                  out_last, want.last));
                    if (truncated !== want.trunc)
                        report_mismatch($sformatf("truncated %b, want %b",
                                                  truncated, want.trunc));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:  cur_mode = cfg_data[0];
                    CFG_LIMIT: cur_limit = cfg_data;
                    default:   ;
                endcase
            end
            if (in_valid && !in_stall)
                translate_char(in_byte, in_last);
        end
        owed_count = owed_results.size();
    end

endmodule

[bench/byte_escape_codec_tb.sv]
`timescale 1ns / 1ps
// top of the byte escape codec bench: clock, reset, stimulus, watchdog and verdict
module byte_escape_codec_tb;
    import bec_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 1050;
    localparam int QUIET_FROM     = 880;

    // indexes past the register list, writes there must be ignored
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    localparam logic [3:0][7:0] RAW_CHARS = {8'h5C, 8'h7C, 8'h2C, 8'h0A};
    localparam logic [3:0][7:0] ESC_CODES = {8'h79, 8'h7A, 8'h63, 8'h6E};

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index  = CFG_MODE;
    logic [15:0] cfg_data   = 16'h0000;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte    = 8'h00;
    logic        in_last    = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        out_last;
    logic        truncated;

    int   mismatch_count;
    int   owed_count;
    int   items_sent  = 0;
    int   gap_pct     = 0;
    int   stall_pct   = 0;
    int   stall_left  = 0;
    int   idle_cycles = 0;
    logic tb_mode     = MODE_ESCAPE;

    byte_escape_codec DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .out_last   (out_last),
        .truncated  (truncated)
    );

    byte_escape_codec_chk u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .in_last        (in_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .out_last       (out_last),
        .truncated      (truncated),
        .mismatch_count (mismatch_count),
        .owed_count     (owed_count)
    );

    always #HALF_PERIOD clk = ~clk;

    // random receiver back-pressure in bursts
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 12);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // counts cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic fin);
        int gap;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= ch;
        in_last  <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // waits for the codec to drain, including bytes that give no result, then writes
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MODE)
            tb_mode = val[0];
    endtask

    // biased towards map characters so escapes and escape pairs are frequent
    function automatic logic [7:0] pick_char(input logic m);
        int r;
        int slot;
        logic [7:0] c;
        r    = $urandom_range(0, 99);
        slot = $urandom_range(0, 3);
        if (r < 25)
            c = (m == MODE_UNESCAPE) ? BACKSLASH : RAW_CHARS[slot[1:0]];
        else if (r < 45)
            c = ESC_CODES[slot[1:0]];
        else if (r < 50)
            c = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        else
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    initial
    begin
        int r;
        int strings;
        int len;
        logic [15:0] lim;
        logic [15:0] val;
        logic open_end;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        gap_pct   = 30;
        stall_pct = 30;

        // escape mode at reset limit: every map character, byte extremes
        send_char(8'h0A, 1'b0);
        send_char(8'h2C, 1'b0);
        send_char(8'h7C, 1'b0);
        send_char(8'h5C, 1'b0);
        send_char(8'h41, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h01, 1'b1);

        // unescape: each code, an unmapped code, then a trailing lone backslash
        write_reg(CFG_MODE, {15'd0, MODE_UNESCAPE});
        send_char(BACKSLASH, 1'b0);
        send_char(8'h6E, 1'b0);
        send_char(BACKSLASH, 1'b0);
        send_char(8'h63, 1'b0);
        send_char(BACKSLASH, 1'b0);
        send_char(8'h7A, 1'b0);
        send_char(BACKSLASH, 1'b0);
        send_char(8'h79, 1'b0);
        send_char(BACKSLASH, 1'b0);
        send_char(8'h41, 1'b0);
        send_char(BACKSLASH, 1'b1);

        // mode switched while a backslash is held
        send_char(BACKSLASH, 1'b0);
        write_reg(CFG_MODE, {15'd0, MODE_ESCAPE});
        send_char(8'h2C, 1'b0);
        send_char(8'h42, 1'b1);

        // escape pair does not fit under a small limit
        write_reg(CFG_LIMIT, 16'd3);
        send_char(8'h41, 1'b0);
        send_char(8'h0A, 1'b0);
        send_char(8'h42, 1'b1);

        // zero limit cuts the first byte
        write_reg(CFG_LIMIT, 16'd0);
        send_char(8'h41, 1'b1);

        write_reg(CFG_SPARE_LO, 16'h0000);
        write_reg(CFG_SPARE_HI, 16'hFFFF);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_FROM)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = 20 * $urandom_range(0, 2);
                stall_pct = 20 * $urandom_range(0, 2);
            end
            r = $urandom_range(0, 19);
            if (r == 0)
                lim = 16'd0;
            else if (r == 1)
                lim = 16'd1;
            else if (r == 2)
                lim = LIMIT_RESET;
            else if (r == 3)
                lim = 16'($urandom_range(0, 65535));
            else
                lim = 16'($urandom_range(2, 40));
            r = $urandom_range(0, 7);
            if (r != 0)
            begin
                val = 16'($urandom_range(0, 65535));
                write_reg(CFG_MODE, val);
            end
            if (r != 1)
                write_reg(CFG_LIMIT, lim);
            if (r == 2)
            begin
                val = 16'($urandom_range(0, 65535));
                write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO, val);
            end
            strings = $urandom_range(1, 4);
            for (int s = 0; s < strings; s++)
            begin
                len = $urandom_range(1, 24);
                // an open string carries its state into the next setting
                open_end = (s == strings - 1) && ($urandom_range(0, 6) == 0);
                for (int k = 0; k < len; k++)
                    send_char(pick_char(tb_mode), (k == len - 1) && !open_end);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_count != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
src/bec_pkg.sv
src/bec_core.sv
src/byte_escape_codec.sv
src/bec_checker.sv
bench/byte_escape_codec_chk.sv
bench/byte_escape_codec_tb.sv
